/* rtl/mpp_pkg.sv */
// Package for the motion data packet parser: widths, field offsets, status codes
// and the reflected CRC-32 lookup table. No dependencies.
`default_nettype none
package mpp_pkg;

	localparam int COUNT_WIDTH = 16;
	localparam int MIN_PACKET_BYTES = 100;

	typedef logic [COUNT_WIDTH-1:0] count_t;
	typedef logic [31:0] crc_table_t [256];

	localparam logic [31:0] CRC_POLY = 32'hEDB88320;
	localparam logic [31:0] CRC_INIT = 32'hFFFFFFFF;

	localparam int MAGIC_AT = 0;
	localparam int VERSION_AT = 4;
	localparam int CRC_FIELD_AT = 8;
	localparam int TYPE_AT = 16;
	localparam int SLOT_AT = 20;
	localparam int SLOT_STATE_AT = 21;
	localparam int TIME_AT = 68;
	localparam int MOTION_AT = 76;
	localparam int MOTION_COUNT = 6;
	localparam int MOTION_BYTES = 4 * MOTION_COUNT;

	localparam logic [15:0] PROTO_VERSION = 16'd1001;
	localparam logic [31:0] MSG_TYPE_DATA = 32'h0010_0002;
	localparam logic [31:0] MAGIC_WORD = {8'h53, 8'h55, 8'h53, 8'h44};

	localparam int FLAG_MAGIC = 0;
	localparam int FLAG_VERSION = 1;
	localparam int FLAG_TYPE = 2;

	localparam logic [2:0] ST_OK = 3'd0;
	localparam logic [2:0] ST_SHORT = 3'd1;
	localparam logic [2:0] ST_MAGIC = 3'd2;
	localparam logic [2:0] ST_VERSION = 3'd3;
	localparam logic [2:0] ST_TYPE = 3'd4;
	localparam logic [2:0] ST_CRC = 3'd5;
	localparam logic [2:0] ST_SLOT = 3'd6;

	function automatic crc_table_t crc_build();
		crc_table_t tbl;
		logic [31:0] c;
		for (int i = 0; i < 256; i++) begin
			c = 32'(i);
			for (int j = 0; j < 8; j++) begin
				c = c[0] ? (CRC_POLY ^ (c >> 1)) : (c >> 1);
			end
			tbl[i] = c;
		end
		return tbl;
	endfunction

	localparam crc_table_t CRC_TABLE = crc_build();

endpackage
`default_nettype wire

/* rtl/motion_packet_parser_crc32.sv */
// Motion data packet parser top level: byte-wide CRC-32 check, header checks and
// field capture over one datagram. Depends on mpp_pkg.
//
// One byte per cycle is accepted, back to back, while in_stall is low; the last byte
// is registered in the input stage, its result then on the output. A result waiting
// on the output only stalls the input when the next last byte reaches the processing
// stage. Reset clears the byte count, the fields under capture and both valid flags.
`default_nettype none
module motion_packet_parser_crc32 import mpp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  packet_byte,
	input  wire logic        last_byte,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [2:0]       status,
	output logic [7:0]       slot_number,
	output logic [63:0]      stamp_us,
	output logic [31:0]      accel_x_bits,
	output logic [31:0]      accel_y_bits,
	output logic [31:0]      accel_z_bits,
	output logic [31:0]      gyro_x_bits,
	output logic [31:0]      gyro_y_bits,
	output logic [31:0]      gyro_z_bits
);

	localparam count_t COUNT_MAX = '1;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic        advance;

	count_t      pos_q;
	logic [31:0] crc_q;
	logic [31:0] rx_crc_q;
	logic [2:0]  flags_q;
	logic [7:0]  slot_q;
	logic        active_q;
	logic [63:0] time_q;
	logic [31:0] motion_q [MOTION_COUNT];

	logic [31:0] crc_d;
	logic [31:0] rx_crc_d;
	logic [2:0]  flags_d;
	logic [7:0]  slot_d;
	logic        active_d;
	logic [63:0] time_d;
	logic [31:0] motion_d [MOTION_COUNT];
	logic [7:0]  fed;
	logic [4:0]  rel;
	logic [2:0]  time_rel;
	logic [2:0]  status_d;

	logic        out_valid_q;
	logic [2:0]  status_q;
	logic [7:0]  slot_out_q;
	logic [63:0] time_out_q;
	logic [31:0] motion_out_q [MOTION_COUNT];

	assign advance = valid_s1 && (!last_s1 || !out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!valid_s1 || advance) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if ((!valid_s1 || advance) && in_valid) begin
			byte_s1 <= packet_byte;
			last_s1 <= last_byte;
		end
	end

	always_comb begin
		fed = byte_s1;
		rx_crc_d = rx_crc_q;
		flags_d = flags_q;
		slot_d = slot_q;
		active_d = active_q;
		time_d = time_q;
		motion_d = motion_q;
		rel = 5'(pos_q - count_t'(MOTION_AT));
		time_rel = 3'(pos_q - count_t'(TIME_AT));
		if (pos_q < count_t'(VERSION_AT)) begin
			if (byte_s1 != MAGIC_WORD[8*pos_q[1:0] +: 8]) begin
				flags_d[FLAG_MAGIC] = 1'b0;
			end
		end else if (pos_q < count_t'(VERSION_AT + 2)) begin
			if (byte_s1 != PROTO_VERSION[8*pos_q[0] +: 8]) begin
				flags_d[FLAG_VERSION] = 1'b0;
			end
		end else if (pos_q >= count_t'(CRC_FIELD_AT) && pos_q < count_t'(CRC_FIELD_AT + 4)) begin
			rx_crc_d[8*pos_q[1:0] +: 8] = byte_s1;
			fed = 8'h00;
		end else if (pos_q >= count_t'(TYPE_AT) && pos_q < count_t'(TYPE_AT + 4)) begin
			if (byte_s1 != MSG_TYPE_DATA[8*pos_q[1:0] +: 8]) begin
				flags_d[FLAG_TYPE] = 1'b0;
			end
		end else if (pos_q == count_t'(SLOT_AT)) begin
			slot_d = byte_s1;
		end else if (pos_q == count_t'(SLOT_STATE_AT)) begin
			active_d = (byte_s1 != 8'h00);
		end else if (pos_q >= count_t'(TIME_AT) && pos_q < count_t'(TIME_AT + 8)) begin
			time_d[8*time_rel +: 8] = byte_s1;
		end else if (pos_q >= count_t'(MOTION_AT) && pos_q < count_t'(MOTION_AT + MOTION_BYTES)) begin
			motion_d[rel[4:2]][8*rel[1:0] +: 8] = byte_s1;
		end
		crc_d = CRC_TABLE[crc_q[7:0] ^ fed] ^ (crc_q >> 8);

		if (pos_q < count_t'(MIN_PACKET_BYTES - 1)) begin
			status_d = ST_SHORT;
		end else if (!flags_d[FLAG_MAGIC]) begin
			status_d = ST_MAGIC;
		end else if (!flags_d[FLAG_VERSION]) begin
			status_d = ST_VERSION;
		end else if (!flags_d[FLAG_TYPE]) begin
			status_d = ST_TYPE;
		end else if ((crc_d ^ CRC_INIT) != rx_crc_d) begin
			status_d = ST_CRC;
		end else if (!active_d) begin
			status_d = ST_SLOT;
		end else begin
			status_d = ST_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			crc_q <= CRC_INIT;
			rx_crc_q <= '0;
			flags_q <= 3'b111;
			slot_q <= '0;
			active_q <= 1'b0;
			time_q <= '0;
			for (int k = 0; k < MOTION_COUNT; k++) begin
				motion_q[k] <= '0;
			end
		end else if (advance) begin
			if (last_s1) begin
				pos_q <= '0;
				crc_q <= CRC_INIT;
				rx_crc_q <= '0;
				flags_q <= 3'b111;
				slot_q <= '0;
				active_q <= 1'b0;
				time_q <= '0;
				for (int k = 0; k < MOTION_COUNT; k++) begin
					motion_q[k] <= '0;
				end
			end else begin
				pos_q <= (pos_q == COUNT_MAX) ? COUNT_MAX : pos_q + count_t'(1);
				crc_q <= crc_d;
				rx_crc_q <= rx_crc_d;
				flags_q <= flags_d;
				slot_q <= slot_d;
				active_q <= active_d;
				time_q <= time_d;
				motion_q <= motion_d;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			status_q <= status_d;
			if (status_d == ST_OK) begin
				slot_out_q <= slot_d;
				time_out_q <= time_d;
				motion_out_q <= motion_d;
			end else begin
				slot_out_q <= '0;
				time_out_q <= '0;
				for (int k = 0; k < MOTION_COUNT; k++) begin
					motion_out_q[k] <= '0;
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign slot_number = slot_out_q;
	assign stamp_us = time_out_q;
	assign accel_x_bits = motion_out_q[0];
	assign accel_y_bits = motion_out_q[1];
	assign accel_z_bits = motion_out_q[2];
	assign gyro_x_bits = motion_out_q[3];
	assign gyro_y_bits = motion_out_q[4];
	assign gyro_z_bits = motion_out_q[5];

endmodule
`default_nettype wire

/* test/motion_packet_checker.sv */
// Result checker for the motion data packet parser: a CRC-32 helper package and a
// module that watches both channels, predicts each datagram's report and compares.
// Depends on mpp_pkg.
package mpp_tb_pkg;
	import mpp_pkg::*;

	function automatic logic [31:0] crc32_step(logic [31:0] crc, logic [7:0] b);
		logic [31:0] c;
		c = crc ^ {24'h0, b};
		for (int j = 0; j < 8; j++) begin
			c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

endpackage

module motion_packet_checker import mpp_pkg::*, mpp_tb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  packet_byte,
	input  logic        last_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [2:0]  status,
	input  logic [7:0]  slot_number,
	input  logic [63:0] stamp_us,
	input  logic [31:0] accel_x_bits,
	input  logic [31:0] accel_y_bits,
	input  logic [31:0] accel_z_bits,
	input  logic [31:0] gyro_x_bits,
	input  logic [31:0] gyro_y_bits,
	input  logic [31:0] gyro_z_bits,
	output int          fail_count,
	output int          reports_waiting
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [2:0] status;
		logic [7:0] slot;
		logic [63:0] stamp;
		logic [MOTION_COUNT-1:0][31:0] motion;
	} report_t;

	report_t expected_reports [$];

	count_t next_pos;
	logic [31:0] crc_acc;
	logic [31:0] crc_stored;
	logic magic_ok;
	logic version_ok;
	logic type_ok;
	logic slot_on;
	logic [7:0] slot_byte;
	logic [63:0] stamp_acc;
	logic [MOTION_COUNT-1:0][31:0] motion_acc;

	string motion_names [MOTION_COUNT] = '{"accel_x_bits", "accel_y_bits", "accel_z_bits",
		"gyro_x_bits", "gyro_y_bits", "gyro_z_bits"};

	function automatic void start_datagram();
		next_pos = '0;
		crc_acc = CRC_INIT;
		crc_stored = '0;
		magic_ok = 1'b1;
		version_ok = 1'b1;
		type_ok = 1'b1;
		slot_on = 1'b0;
		slot_byte = '0;
		stamp_acc = '0;
		motion_acc = '0;
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic last);
		int pos;
		int rel;
		logic [7:0] fed;
		report_t r;
		pos = int'(next_pos);
		fed = b;
		if (pos < VERSION_AT) begin
			if (b != MAGIC_WORD[8*pos +: 8]) magic_ok = 1'b0;
		end else if (pos < VERSION_AT + 2) begin
			if (b != PROTO_VERSION[8*(pos-VERSION_AT) +: 8]) version_ok = 1'b0;
		end else if (pos >= CRC_FIELD_AT && pos < CRC_FIELD_AT + 4) begin
			crc_stored[8*(pos-CRC_FIELD_AT) +: 8] = b;
			fed = 8'h00;
		end else if (pos >= TYPE_AT && pos < TYPE_AT + 4) begin
			if (b != MSG_TYPE_DATA[8*(pos-TYPE_AT) +: 8]) type_ok = 1'b0;
		end else if (pos == SLOT_AT) begin
			slot_byte = b;
		end else if (pos == SLOT_STATE_AT) begin
			slot_on = (b != 8'h00);
		end else if (pos >= TIME_AT && pos < TIME_AT + 8) begin
			stamp_acc[8*(pos-TIME_AT) +: 8] = b;
		end else if (pos >= MOTION_AT && pos < MOTION_AT + MOTION_BYTES) begin
			rel = pos - MOTION_AT;
			motion_acc[rel >> 2][8*(rel & 3) +: 8] = b;
		end
		crc_acc = crc32_step(crc_acc, fed);
		if (next_pos != '1) next_pos = next_pos + 1'b1;
		if (!last) return;

		r = '0;
		if (pos + 1 < MIN_PACKET_BYTES) r.status = ST_SHORT;
		else if (!magic_ok) r.status = ST_MAGIC;
		else if (!version_ok) r.status = ST_VERSION;
		else if (!type_ok) r.status = ST_TYPE;
		else if ((crc_acc ^ CRC_INIT) != crc_stored) r.status = ST_CRC;
		else if (!slot_on) r.status = ST_SLOT;
		else r.status = ST_OK;
		if (r.status == ST_OK) begin
			r.slot = slot_byte;
			r.stamp = stamp_acc;
			r.motion = motion_acc;
		end
		expected_reports.push_back(r);
		start_datagram();
	endtask

	task automatic compare_field(input string name, input logic [63:0] want,
		input logic [63:0] seen);
		if (want !== seen) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("Mismatch on %s: expected %h, got %h", name, want, seen);
			end
		end
	endtask

	task automatic check_report();
		report_t want;
		logic [31:0] seen [MOTION_COUNT];
		seen = '{accel_x_bits, accel_y_bits, accel_z_bits, gyro_x_bits, gyro_y_bits,
			gyro_z_bits};
		if (expected_reports.size() == 0) begin
			fail_count++;
			if (fail_count <= 10) begin
				$display("Result transaction with no datagram pending: status %0d", status);
			end
			return;
		end
		want = expected_reports.pop_front();
		compare_field("status", 64'(want.status), 64'(status));
		compare_field("slot_number", 64'(want.slot), 64'(slot_number));
		compare_field("stamp_us", want.stamp, stamp_us);
		for (int k = 0; k < MOTION_COUNT; k++) begin
			compare_field(motion_names[k], 64'(want.motion[k]), 64'(seen[k]));
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_datagram();
			expected_reports.delete();
			reports_waiting <= 0;
		end else begin
			if (in_valid && !in_stall) parse_byte(packet_byte, last_byte);
			if (out_valid && !out_stall) check_report();
			reports_waiting <= expected_reports.size();
		end
	end

endmodule

/* test/testbench.sv */
// Top of the motion data packet parser testbench: clock, reset, datagram stimulus
// with random idling and back-pressure, and the final verdict.
// Depends on mpp_pkg, mpp_tb_pkg, motion_packet_parser_crc32 and motion_packet_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mpp_pkg::*;
	import mpp_tb_pkg::*;

	localparam int LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 400;

	localparam logic [4:0] FAULT_NONE = 5'b00000;
	localparam logic [4:0] FAULT_MAGIC = 5'b00001;
	localparam logic [4:0] FAULT_VERSION = 5'b00010;
	localparam logic [4:0] FAULT_TYPE = 5'b00100;
	localparam logic [4:0] FAULT_CRC = 5'b01000;
	localparam logic [4:0] FAULT_SLOT = 5'b10000;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_NOISE} fill_t;

	logic clk;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] packet_byte = 8'h00;
	logic last_byte = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [7:0] slot_number;
	logic [63:0] stamp_us;
	logic [31:0] accel_x_bits;
	logic [31:0] accel_y_bits;
	logic [31:0] accel_z_bits;
	logic [31:0] gyro_x_bits;
	logic [31:0] gyro_y_bits;
	logic [31:0] gyro_z_bits;
	int fail_count;
	int reports_waiting;

	logic send_idle = 1'b0;
	logic recv_idle = 1'b0;
	logic hold_long = 1'b0;
	int cycles = 0;
	int sent_bytes = 0;
	int packets = 0;
	logic [7:0] datagram [$];

	motion_packet_parser_crc32 uut (.*);

	motion_packet_checker check (.*);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("** motion_packet_parser_crc32: FAILED **");
			$finish;
		end
	end

	initial begin
		forever begin
			@(negedge clk);
			if (hold_long) begin
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_long = 1'b0;
				out_stall <= 1'b0;
			end else if (recv_idle && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	function automatic void place(int at, logic [7:0] v);
		if (at < datagram.size()) datagram[at] = v;
	endfunction

	function automatic void flip_bit(int at);
		if (at < datagram.size()) datagram[at] = datagram[at] ^ 8'(1 << $urandom_range(0, 7));
	endfunction

	function automatic void build_datagram(int len, fill_t fill, logic [4:0] faults);
		logic [31:0] crc;
		datagram.delete();
		for (int i = 0; i < len; i++) begin
			if (fill == FILL_ZERO) datagram.push_back(8'h00);
			else if (fill == FILL_ONES) datagram.push_back(8'hFF);
			else datagram.push_back(8'($urandom));
		end
		if (fill == FILL_NOISE) return;
		for (int k = 0; k < 4; k++) begin
			place(MAGIC_AT + k, MAGIC_WORD[8*k +: 8]);
			place(TYPE_AT + k, MSG_TYPE_DATA[8*k +: 8]);
		end
		for (int k = 0; k < 2; k++) begin
			place(VERSION_AT + k, PROTO_VERSION[8*k +: 8]);
		end
		if (fill == FILL_ZERO) place(SLOT_STATE_AT, 8'h01);
		else if (fill == FILL_ONES) place(SLOT_STATE_AT, 8'hFF);
		else place(SLOT_STATE_AT, 8'($urandom_range(1, 255)));
		if ((faults & FAULT_MAGIC) != 0) flip_bit(MAGIC_AT + $urandom_range(0, 3));
		if ((faults & FAULT_VERSION) != 0) flip_bit(VERSION_AT + $urandom_range(0, 1));
		if ((faults & FAULT_TYPE) != 0) flip_bit(TYPE_AT + $urandom_range(0, 3));
		if ((faults & FAULT_SLOT) != 0) place(SLOT_STATE_AT, 8'h00);
		crc = CRC_INIT;
		for (int i = 0; i < len; i++) begin
			crc = crc32_step(crc, (i >= CRC_FIELD_AT && i < CRC_FIELD_AT + 4) ? 8'h00 : datagram[i]);
		end
		crc = crc ^ CRC_INIT;
		for (int k = 0; k < 4; k++) begin
			place(CRC_FIELD_AT + k, crc[8*k +: 8]);
		end
		if ((faults & FAULT_CRC) != 0) begin
			if (len > SLOT_STATE_AT + 1 && $urandom_range(0, 1) == 1) begin
				flip_bit($urandom_range(SLOT_STATE_AT + 1, len - 1));
			end else begin
				flip_bit(CRC_FIELD_AT + $urandom_range(0, 3));
			end
		end
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		@(negedge clk);
		if (send_idle && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(negedge clk);
		end
		in_valid <= 1'b1;
		packet_byte <= b;
		last_byte <= last;
		do @(posedge clk); while (in_stall);
	endtask

	task automatic run_packet(input int len, input fill_t fill, input logic [4:0] faults);
		build_datagram(len, fill, faults);
		for (int i = 0; i < datagram.size(); i++) begin
			send_byte(datagram[i], i == datagram.size() - 1);
		end
		packets++;
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (reports_waiting != 0) @(negedge clk);
	endtask

	task automatic random_packet();
		int pick;
		int len;
		int shade;
		logic [4:0] faults;
		fill_t fill;
		pick = $urandom_range(0, 99);
		shade = $urandom_range(0, 19);
		fill = FILL_RANDOM;
		if (shade == 0) fill = FILL_ZERO;
		else if (shade == 1) fill = FILL_ONES;
		faults = FAULT_NONE;
		len = MIN_PACKET_BYTES;
		if (pick < 55) begin
			if ($urandom_range(0, 9) == 0) len = $urandom_range(MIN_PACKET_BYTES + 1,
				MIN_PACKET_BYTES + 40);
		end else if (pick < 80) begin
			faults = 5'(1 << $urandom_range(0, 4));
		end else if (pick < 86) begin
			faults = 5'($urandom_range(1, 31));
		end else if (pick < 94) begin
			len = $urandom_range(1, MIN_PACKET_BYTES - 1);
		end else begin
			len = $urandom_range(1, MIN_PACKET_BYTES + 40);
			fill = FILL_NOISE;
		end
		run_packet(len, fill, faults);
		sent_bytes += len;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		send_idle = 1'b1;
		recv_idle = 1'b1;
		run_packet(MIN_PACKET_BYTES, FILL_ONES, FAULT_NONE);
		run_packet(MIN_PACKET_BYTES, FILL_ZERO, FAULT_NONE);
		run_packet(1, FILL_RANDOM, FAULT_NONE);
		run_packet(1, FILL_ONES, FAULT_NONE);
		run_packet(MIN_PACKET_BYTES - 1, FILL_RANDOM, FAULT_NONE);
		run_packet(SLOT_STATE_AT + 2, FILL_RANDOM, FAULT_NONE);
		run_packet(MIN_PACKET_BYTES, FILL_RANDOM, FAULT_MAGIC);
		run_packet(MIN_PACKET_BYTES, FILL_RANDOM, FAULT_VERSION);
		run_packet(MIN_PACKET_BYTES, FILL_RANDOM, FAULT_TYPE);
		run_packet(MIN_PACKET_BYTES, FILL_RANDOM, FAULT_CRC);
		run_packet(MIN_PACKET_BYTES, FILL_RANDOM, FAULT_SLOT);
		run_packet(MIN_PACKET_BYTES, FILL_RANDOM,
			FAULT_MAGIC | FAULT_VERSION | FAULT_TYPE | FAULT_CRC | FAULT_SLOT);
		run_packet(MIN_PACKET_BYTES, FILL_RANDOM, FAULT_TYPE | FAULT_CRC | FAULT_SLOT);
		run_packet(MIN_PACKET_BYTES, FILL_RANDOM, FAULT_CRC | FAULT_SLOT);
		run_packet(MIN_PACKET_BYTES + 60, FILL_RANDOM, FAULT_NONE);
		run_packet(MIN_PACKET_BYTES, FILL_NOISE, FAULT_NONE);

		// The byte counter saturates well before the end of this datagram.
		send_idle = 1'b0;
		recv_idle = 1'b0;
		run_packet((1 << COUNT_WIDTH) + 40, FILL_RANDOM, FAULT_NONE);
		run_packet(MIN_PACKET_BYTES, FILL_RANDOM, FAULT_NONE);
		drain();

		// Short datagrams pile up behind a long output stall and back up the input.
		hold_long = 1'b1;
		for (int n = 0; n < 16; n++) begin
			run_packet($urandom_range(1, 4), FILL_RANDOM, FAULT_NONE);
		end
		@(negedge clk);
		in_valid <= 1'b0;
		while (hold_long) @(negedge clk);
		drain();

		send_idle = 1'b1;
		recv_idle = 1'b1;
		sent_bytes = 0;
		packets = 0;
		while (sent_bytes < 900 || packets < 60) begin
			if (packets == 30) drain();
			if (packets == 50) begin
				send_idle = 1'b0;
				recv_idle = 1'b0;
			end
			random_packet();
		end

		@(negedge clk);
		in_valid <= 1'b0;
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && reports_waiting == 0) begin
			$display("** motion_packet_parser_crc32: PASSED **");
		end else begin
			$display("** motion_packet_parser_crc32: FAILED **");
		end
		$finish;
	end

endmodule
